### hdl/med_pkg.sv
// Shared widths, constants and state type for the mean Euclidean distance block.
package med_pkg;

    localparam int COORD_W    = 16;               // point and reference coordinates
    localparam int DIFF_W     = COORD_W + 1;      // exact coordinate difference
    localparam int SQ_W       = 2 * COORD_W + 2;  // dx*dx + dy*dy
    localparam int FRAC_W     = 8;                // fraction bits of a distance
    localparam int RAD_W      = SQ_W + 2 * FRAC_W;
    localparam int ROOT_W     = RAD_W / 2;        // distance width
    localparam int CNT_W      = 17;               // point counter
    localparam int SUM_W      = ROOT_W + CNT_W - 1;
    localparam int MAX_POINTS = 65536;
    localparam int TDATA_IN_W  = 2 * COORD_W;
    localparam int TDATA_OUT_W = ((ROOT_W + CNT_W + 7) / 8) * 8;

    // configuration register indexes
    localparam logic REG_REF_X = 1'b0;
    localparam logic REG_REF_Y = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

### hdl/med_square.sv
// Bit-serial sum of squares: ux*ux + uy*uy, one multiplier bit per cycle.
module med_square (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [med_pkg::COORD_W-1:0]   ux,
    input  logic [med_pkg::COORD_W-1:0]   uy,
    output logic [med_pkg::SQ_W-1:0]      sq,
    output logic                          done
);
    import med_pkg::*;

    localparam int CW = $clog2(COORD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [COORD_W-1:0]  ux_reg, uy_reg, mx_reg, my_reg;
    logic [SQ_W-1:0]     acc_reg;
    logic [SQ_W-COORD_W:0] sum;  // upper half plus both partial products
    logic                last_step;

    always_comb
    begin
        sum = {1'b0, acc_reg[SQ_W-1:COORD_W]}
            + (mx_reg[0] ? {{(SQ_W-2*COORD_W+1){1'b0}}, ux_reg} : '0)
            + (my_reg[0] ? {{(SQ_W-2*COORD_W+1){1'b0}}, uy_reg} : '0);
    end

    // done pulses once the final partial product has landed in acc_reg
    assign last_step = busy_reg && (cnt_reg == CW'(COORD_W - 1));
    assign done      = done_reg;
    assign sq        = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last_step;
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ux_reg  <= ux;
            uy_reg  <= uy;
            mx_reg  <= ux;
            my_reg  <= uy;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            mx_reg  <= mx_reg >> 1;
            my_reg  <= my_reg >> 1;
            acc_reg <= {sum, acc_reg[COORD_W-1:1]};
        end
    end

endmodule

### hdl/med_sqrt.sv
// Restoring square root, one root bit per cycle, radicand scaled by 2^16.
module med_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [med_pkg::SQ_W-1:0]    sq,
    output logic [med_pkg::ROOT_W-1:0]  root,
    output logic                        done
);
    import med_pkg::*;

    localparam int CW    = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 1;   // remainder never exceeds 2*root

    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    diff;
    logic                fits;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    assign done = busy_reg && (cnt_reg == CW'(ROOT_W - 1));
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {sq, {(2*FRAC_W){1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

endmodule

### hdl/med_div.sv
// Restoring divider for sum / count, one quotient bit per cycle.
module med_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [med_pkg::SUM_W-1:0]   dividend,
    input  logic [med_pkg::CNT_W-1:0]   divisor,
    output logic [med_pkg::ROOT_W-1:0]  quotient,
    output logic                        done
);
    import med_pkg::*;

    localparam int CW = $clog2(SUM_W);

    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [SUM_W-1:0]    q_reg;     // dividend shifts out, quotient shifts in
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      diff;
    logic                fits;

    always_comb
    begin
        rem_sh = {rem_reg, q_reg[SUM_W-1]};
        diff   = rem_sh - {1'b0, div_reg};
        fits   = (rem_sh >= {1'b0, div_reg});
    end

    assign done     = busy_reg && (cnt_reg == CW'(SUM_W - 1));
    assign quotient = q_reg[ROOT_W-1:0];  // mean never exceeds the largest distance

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

endmodule

### hdl/mean_euclidean_distance.sv
// Top level: mean Euclidean distance of a point stream to a reference point.
//
// Each accepted word is one 2D point. The block forms dx, dy against the
// reference point (ref_x, ref_y), squares and sums them in a bit-serial
// multiplier that then hands the sum to the root, takes a restoring square
// root one bit per cycle to get the distance with 8 fraction bits,
// truncated, and adds it to a running sum. s_tready is high only between
// points. On a word with s_tlast set, a serial divider (launched from its
// own state, then one step per bit of the sum) produces floor(sum / count),
// which goes out with the count as one output word, after which sum and
// count clear. After 65536 points further points are taken and dropped,
// neither summed nor counted, until the last point arrives, which then goes
// straight to the divider. The output word sits in its own register, so a
// new point is taken while a result waits for m_tready. The reference point
// is written through cfg_wen/cfg_index/cfg_data; the user must write it only
// while no point is in flight, as the block itself does not enforce this.
module mean_euclidean_distance (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [med_pkg::TDATA_IN_W-1:0]     s_tdata,   // point_x, point_y
    input  logic                               s_tlast,   // last_point
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [med_pkg::TDATA_OUT_W-1:0]    m_tdata,   // mean_distance, point_count, zero pad
    // configuration
    input  logic                               cfg_wen,
    input  logic                               cfg_index,
    input  logic [med_pkg::COORD_W-1:0]        cfg_data
);
    import med_pkg::*;

    state_t              state_reg, state_next;
    logic [COORD_W-1:0]  ref_x_reg, ref_y_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                last_reg;
    logic                m_valid_reg;
    logic [ROOT_W-1:0]   mean_reg;
    logic [CNT_W-1:0]    count_out_reg;

    logic                in_accept;
    logic                count_full;
    logic [DIFF_W-1:0]   dx, dy;
    logic [COORD_W-1:0]  ux, uy;
    logic                sq_start, root_start, div_start;
    logic                sq_done, root_done, div_done;
    logic [SQ_W-1:0]     sq;
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   quotient;
    logic                emit;

    assign in_accept  = s_tvalid && s_tready;
    assign count_full = (count_reg == CNT_W'(MAX_POINTS));

    // exact differences, then magnitudes (at most 65535)
    always_comb
    begin
        dx = {s_tdata[COORD_W-1], s_tdata[COORD_W-1:0]} - {ref_x_reg[COORD_W-1], ref_x_reg};
        dy = {s_tdata[2*COORD_W-1], s_tdata[2*COORD_W-1:COORD_W]}
           - {ref_y_reg[COORD_W-1], ref_y_reg};
        ux = dx[DIFF_W-1] ? COORD_W'(~dx + 1'b1) : dx[COORD_W-1:0];
        uy = dy[DIFF_W-1] ? COORD_W'(~dy + 1'b1) : dy[COORD_W-1:0];
    end

    med_square u_square (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .ux    (ux),
        .uy    (uy),
        .sq    (sq),
        .done  (sq_done)
    );

    med_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .sq    (sq),
        .root  (root),
        .done  (root_done)
    );

    med_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // control
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        sq_start   = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!count_full)
                    begin
                        sq_start   = 1'b1;
                        state_next = ST_SQUARE;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_LAUNCH;  // dropped last point still reports
                    end
                end
            end
            ST_SQUARE:
            begin
                if (sq_done)
                begin
                    root_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = last_reg ? ST_LAUNCH : ST_IDLE;
            end
            ST_LAUNCH:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ref_x_reg   <= '0;
            ref_y_reg   <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_REF_X: ref_x_reg <= cfg_data;
                    REG_REF_Y: ref_y_reg <= cfg_data;
                    default:   ;
                endcase
            end

            if (in_accept)
                last_reg <= s_tlast;

            if (state_reg == ST_ACCUM)
            begin
                sum_reg   <= sum_reg + SUM_W'(root);
                count_reg <= count_reg + 1'b1;
            end
            else if (emit)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end

            if (emit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            mean_reg      <= quotient;
            count_out_reg <= count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-ROOT_W-CNT_W){1'b0}}, count_out_reg, mean_reg};

endmodule

### tb/mean_euclidean_distance_tb.sv
// Testbench for mean_euclidean_distance: streams point sets and checks each mean word.
module mean_euclidean_distance_tb;

    import med_pkg::*;

    // Run limit in clock cycles. Roughly 1000 points, plus the long hold-off
    // and the settle gaps, stay well under it.
    localparam longint RUN_LIMIT  = 1_000_000;
    // Cycles to wait once nothing is pending: more than a last point takes.
    localparam int     SETTLE_CYC = 120;
    // Long receiver hold-off, long enough to back the block up into its input.
    localparam int     HOLD_CYC   = 3000;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata;    // point_x, point_y
    logic                    s_tlast;    // last_point
    logic                    m_tvalid;
    logic                    m_tready;
    logic [TDATA_OUT_W-1:0]  m_tdata;    // mean_distance, point_count, zero pad
    logic                    cfg_wen;
    logic                    cfg_index;
    logic [COORD_W-1:0]      cfg_data;

    mean_euclidean_distance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Distance predictor and expected-mean store.
    // Keeps its own copy of the reference point, the running sum and the
    // point count; every accepted point goes through note_point, and every
    // output word through check_result.
    // ------------------------------------------------------------------
    class mean_distance_board;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [SUM_W-1:0]          running_sum;
        logic [CNT_W-1:0]          points_summed;
        logic [ROOT_W-1:0]         mean_q[$];
        logic [CNT_W-1:0]          count_q[$];
        int                        errors;

        function new();
            center_x      = '0;
            center_y      = '0;
            running_sum   = '0;
            points_summed = '0;
            errors        = 0;
        endfunction

        function void set_reference(logic idx, logic [COORD_W-1:0] value);
            if (idx == REG_REF_X)
                center_x = value;
            else
                center_y = value;
        endfunction

        // floor(sqrt(v)), one result bit per pass
        function logic [ROOT_W-1:0] root_of(longint unsigned v);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'h4000_0000_0000_0000;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (v >= root + probe)
                begin
                    v    = v - (root + probe);
                    root = (root >> 1) + probe;
                end
                else
                    root = root >> 1;
                probe = probe >> 2;
            end
            return root[ROOT_W-1:0];
        endfunction

        function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                 logic is_last);
            longint          dx;
            longint          dy;
            longint unsigned sq;
            dx = longint'($signed(px)) - longint'(center_x);
            dy = longint'($signed(py)) - longint'(center_y);
            // past the point limit a point is dropped: neither summed nor counted
            if (points_summed < MAX_POINTS)
            begin
                sq            = dx * dx + dy * dy;
                running_sum   = running_sum + root_of(sq << (2 * FRAC_W));
                points_summed = points_summed + 1'b1;
            end
            if (is_last)
            begin
                mean_q.push_back(ROOT_W'(running_sum / points_summed));
                count_q.push_back(points_summed);
                running_sum   = '0;
                points_summed = '0;
            end
        endfunction

        function void check_result(logic [ROOT_W-1:0] mean, logic [CNT_W-1:0] count);
            logic [ROOT_W-1:0] exp_mean;
            logic [CNT_W-1:0]  exp_count;
            if (mean_q.size() == 0)
            begin
                $error("unexpected word: mean_distance %0d point_count %0d", mean, count);
                errors++;
                return;
            end
            exp_mean  = mean_q.pop_front();
            exp_count = count_q.pop_front();
            if (mean !== exp_mean)
            begin
                $error("mean_distance: expected %0d, got %0d", exp_mean, mean);
                errors++;
            end
            if (count !== exp_count)
            begin
                $error("point_count: expected %0d, got %0d", exp_count, count);
                errors++;
            end
        endfunction

        function int pending();
            return mean_q.size();
        endfunction
    endclass

    mean_distance_board sb;

    // Idle pattern shared by both sides: 0 = a random gap, possibly none, each time,
    // 1 = no idling at all, 2 = mostly back to back with an occasional gap.
    int     pace;
    // Set by the stimulus to make the receiver hold off once for that many cycles.
    int     rx_hold;
    longint cycle_count = 0;

    // 8 time unit clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int draw_gap();
        case (pace)
            1:       return 0;
            2:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: waits a drawn number of cycles with m_tready low, then
    // holds m_tready high until a word is taken. All drives happen on the
    // falling edge; m_tvalid/m_tdata are sampled on the rising edge.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        bit hold_taken;
        m_tready   = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0 && !hold_taken)
            begin
                stall      = rx_hold;
                hold_taken = 1'b1;
            end
            else
                stall = draw_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata[ROOT_W-1:0], m_tdata[ROOT_W+CNT_W-1:ROOT_W]);
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------

    // Offer one point after a drawn gap and wait until the block takes it.
    // With no gap, tvalid simply stays high into the next word.
    task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic is_last);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_point(px, py, is_last);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // Wait for every expected word, then long enough for the block to be idle.
    task automatic settle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Reference point write; only called with the block idle.
    task automatic write_reg(logic idx, logic [COORD_W-1:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        sb.set_reference(idx, value);
    endtask

    function automatic logic [COORD_W-1:0] pick_center();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return COORD_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // Coordinates lean toward the extremes and toward the reference point,
    // where distances are short and truncation of the root matters most.
    function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] center);
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
            3:       return center + 16'($urandom_range(0, 8)) - 16'd4;
            default: return COORD_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // One set of random points; the final point carries tlast.
    task automatic send_random_set(int n_points);
        for (int i = 0; i < n_points; i++)
            send_point(pick_coord(sb.center_x), pick_coord(sb.center_y),
                       i == n_points - 1);
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int set_len;
        int sent;

        sb        = new();
        pace      = 0;
        rx_hold   = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = REG_REF_X;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reference at its reset value (0, 0): zero distance,
        // whole units, a 3-4-5 triangle, single-axis extremes, corner point,
        // and multi-point sets whose mean truncates.
        send_point(16'd0, 16'd0, 1'b1);
        send_point(16'd1, 16'd0, 1'b1);
        send_point(16'd3, 16'd4, 1'b1);
        send_point(16'h8000, 16'd0, 1'b1);
        send_point(16'd0, 16'h7fff, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b1);
        send_point(16'd3, 16'd4, 1'b0);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd1, 16'd1, 1'b1);
        send_point(16'h7fff, 16'hffff, 1'b0);
        send_point(16'hffff, 16'h7fff, 1'b0);
        send_point(16'd5, 16'hfff9, 1'b1);
        stop_sending();
        settle();

        // Reference at the negative corner: largest positive differences.
        write_reg(REG_REF_X, 16'h8000);
        write_reg(REG_REF_Y, 16'h8000);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b1);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'd0, 16'd0, 1'b1);
        stop_sending();
        settle();

        // Reference at the positive corner: largest negative differences.
        write_reg(REG_REF_X, 16'h7fff);
        write_reg(REG_REF_Y, 16'h7fff);
        send_point(16'h8000, 16'h8000, 1'b1);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        send_point(16'h8000, 16'h7fff, 1'b1);
        stop_sending();
        settle();

        // Random phases: new reference each time, idle pattern per set.
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_REF_X, pick_center());
            write_reg(REG_REF_Y, pick_center());
            sent = 0;
            while (sent < 140)
            begin
                pace    = $urandom_range(0, 2);
                set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                      : $urandom_range(1, 6);
                send_random_set(set_len);
                sent += set_len;
            end
            stop_sending();
            settle();
        end

        // Backpressure: the receiver stalls for a long stretch while short sets
        // keep coming, so the output register fills and s_tready stays low.
        pace    = 1;
        rx_hold = HOLD_CYC;
        for (int i = 0; i < 30; i++)
            send_random_set($urandom_range(1, 2));
        stop_sending();
        settle();

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
hdl/med_pkg.sv
hdl/med_square.sv
hdl/med_sqrt.sv
hdl/med_div.sv
hdl/mean_euclidean_distance.sv
tb/mean_euclidean_distance_tb.sv
